/* rtl/brf_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// brf_pkg
// Shared constants, codes and types of the byte ring FIFO with peek.
// ----------------------------------------------------------------------------
package brf_pkg;

    // Default storage depth and burst cap.
    localparam int DEPTH_DEF     = 128;
    localparam int MAX_BURST_DEF = 64;

    // Field widths of the stream items and the register.
    localparam int DATA_W   = 8;
    localparam int OFFS_W   = 7;
    localparam int LEN_W    = 7;
    localparam int REQ_W    = 3;
    localparam int STAT_W   = 2;
    localparam int FILL_W   = 8;
    localparam int CAP_W    = 8;
    localparam int APB_W    = 32;
    localparam int PADDR_W  = 3;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    // Capacity register reset value and its word address.
    localparam logic [CAP_W-1:0] CAP_RESET     = 8'd128;
    localparam logic             ADDR_CAPACITY = 1'b0;

    // Request kinds.
    localparam logic [REQ_W-1:0] REQ_PUT      = 3'd0;
    localparam logic [REQ_W-1:0] REQ_GET      = 3'd1;
    localparam logic [REQ_W-1:0] REQ_PEEK     = 3'd2;
    localparam logic [REQ_W-1:0] REQ_BURST_RD = 3'd3;
    localparam logic [REQ_W-1:0] REQ_BW_OPEN  = 3'd4;
    localparam logic [REQ_W-1:0] REQ_BW_BYTE  = 3'd5;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NO_BURST = 2'd3;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_HOLD = 4'b0010,
        ST_MOD  = 4'b0100,
        ST_READ = 4'b1000
    } state_t;

endpackage
`default_nettype wire

/* rtl/brf_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// brf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module brf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire                      clk,
    input  wire                      we,
    input  wire [$clog2(DEPTH)-1:0]  waddr,
    input  wire [WIDTH-1:0]          wdata,
    input  wire                      re,
    input  wire [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

/* rtl/brf_mod_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// brf_mod_unit
// Iterative remainder unit: one restoring compare-and-subtract per cycle.
// ----------------------------------------------------------------------------
module brf_mod_unit #(
    parameter int XW = 8,
    parameter int CW = 8,
    parameter int PW = 7
) (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            start,
    input  wire  [XW-1:0]  dividend,
    input  wire  [CW-1:0]  divisor,
    output logic           done,
    output logic [PW-1:0]  remainder
);

    localparam int DW = XW + CW;
    localparam int SW = $clog2(XW + 1);

    logic [XW-1:0] x_reg, x_next;
    logic [DW-1:0] d_reg, d_next;
    logic [SW-1:0] step_reg, step_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    // One remainder step per cycle, shifted divisor moves right.
    always_comb
    begin
        x_next    = x_reg;
        d_next    = d_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            x_next    = dividend;
            d_next    = DW'(divisor) << (XW - 1);
            step_next = SW'(XW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (DW'(x_reg) >= d_reg)
            begin
                x_next = x_reg - XW'(d_reg);
            end
            d_next    = d_reg >> 1;
            step_next = step_reg - SW'(1);
            if (step_reg == SW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        d_reg <= d_next;
    end

    assign done      = done_reg;
    assign remainder = PW'(x_reg);

endmodule
`default_nettype wire

/* rtl/byte_ring_fifo_with_peek_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_peek_unit
// Byte ring FIFO with put, get, peek, burst read and reserved burst write.
// ----------------------------------------------------------------------------
// Put, burst-write open, burst-write byte and unknown kinds: result is registered or held
//   while the output stalls; one request per cycle while results are taken.
// Get and burst read: first byte passes the state register, the RAM read register
//   and the output register, then one byte per cycle while results are taken; input
//   waits for the last byte. Peek: remainder steps, RAM read, then output register.
// Reset clears pointers, counts and per-slot valid marks; unwritten slots read zero.
module byte_ring_fifo_with_peek_unit #(
    parameter int DEPTH     = brf_pkg::DEPTH_DEF,
    parameter int MAX_BURST = brf_pkg::MAX_BURST_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    // APB configuration port
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [brf_pkg::PADDR_W-1:0]      paddr,
    input  wire  [brf_pkg::APB_W-1:0]        pwdata,
    output logic [brf_pkg::APB_W-1:0]        prdata,
    output logic                             pready,
    // Request stream
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    // data_in[7:0], offset[14:8], length[21:15], zero[23:22]
    input  wire  [brf_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // req_type[2:0]
    input  wire  [brf_pkg::REQ_W-1:0]        s_axis_tuser,
    // Result stream
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    // data_out[7:0], status[9:8], fill_level[17:10], zero[23:18]
    output logic [brf_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    output logic                             m_axis_tlast
);
    import brf_pkg::*;

    localparam int PW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int XW  = $clog2(DEPTH + 127);
    localparam int BLW = $clog2(MAX_BURST + 1);
    localparam int WW  = CW + 2;

    // Request fields.
    logic [DATA_W-1:0] in_data;
    logic [OFFS_W-1:0] in_offset;
    logic [LEN_W-1:0]  in_length;
    logic [REQ_W-1:0]  in_req;

    assign in_data   = s_axis_tdata[7:0];
    assign in_offset = s_axis_tdata[14:8];
    assign in_length = s_axis_tdata[21:15];
    assign in_req    = s_axis_tuser;

    // Control registers.
    state_t            state_reg, state_next;
    logic [CAP_W-1:0]  cap_reg, cap_next;
    logic [PW-1:0]     head_reg, head_next;
    logic [PW-1:0]     tail_reg, tail_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [BLW-1:0]    bleft_reg, bleft_next;
    logic [BLW-1:0]    rem_reg, rem_next;
    logic              rd_pend_reg, rd_pend_next;
    logic              rd_last_reg, rd_last_next;
    logic [CW-1:0]     rd_fill_reg, rd_fill_next;
    logic              rd_ok_reg, rd_ok_next;
    logic [STAT_W-1:0] pend_stat_reg, pend_stat_next;
    logic [DEPTH-1:0]  valid_reg;

    // Output register.
    logic              m_valid_reg, m_valid_next;
    logic [DATA_W-1:0] m_data_reg, m_data_next;
    logic [STAT_W-1:0] m_stat_reg, m_stat_next;
    logic [FILL_W-1:0] m_fill_reg, m_fill_next;
    logic              m_last_reg, m_last_next;

    // RAM and remainder unit hookup.
    logic              ram_we;
    logic [PW-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_re;
    logic [PW-1:0]     ram_raddr;
    logic [DATA_W-1:0] ram_rdata;
    logic              mod_start;
    logic [XW-1:0]     mod_dividend;
    logic              mod_done;
    logic [PW-1:0]     mod_rem;

    logic [CW-1:0]     cap_eff;
    logic              slot_free;
    logic              in_fire;
    logic              cfg_wr;

    // Clamp the capacity register to 1..DEPTH.
    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = CW'(1);
        end
        else if ((CAP_W + 1)'(cap_reg) > (CAP_W + 1)'(DEPTH))
        begin
            cap_eff = CW'(DEPTH);
        end
        else
        begin
            cap_eff = CW'(cap_reg);
        end
    end

    function automatic logic [PW-1:0] ring_inc(input logic [PW-1:0] p,
                                              input logic [CW-1:0] cap);
        logic [CW-1:0] p1;
        p1 = CW'(p) + CW'(1);
        return (p1 >= cap) ? '0 : PW'(p1);
    endfunction

    assign slot_free     = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign cfg_wr        = psel && penable && pwrite && pready && (paddr[2] == ADDR_CAPACITY);
    assign mod_dividend  = XW'(head_reg) + XW'(in_offset);

    // Request sequencer.
    always_comb
    begin
        logic [BLW-1:0]    len_sat;
        logic              single;
        logic [STAT_W-1:0] sstat;
        logic              can_go;

        state_next     = state_reg;
        cap_next       = cap_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        bleft_next     = bleft_reg;
        rem_next       = rem_reg;
        rd_pend_next   = rd_pend_reg;
        rd_last_next   = rd_last_reg;
        rd_fill_next   = rd_fill_reg;
        rd_ok_next     = rd_ok_reg;
        pend_stat_next = pend_stat_reg;
        m_data_next    = m_data_reg;
        m_stat_next    = m_stat_reg;
        m_fill_next    = m_fill_reg;
        m_last_next    = m_last_reg;
        m_valid_next   = m_valid_reg && !m_axis_tready;
        ram_we         = 1'b0;
        ram_waddr      = tail_reg;
        ram_wdata      = in_data;
        ram_re         = 1'b0;
        ram_raddr      = head_reg;
        mod_start      = 1'b0;
        single         = 1'b0;
        sstat          = STAT_OK;
        can_go         = !rd_pend_reg || slot_free;

        if (in_length > LEN_W'(MAX_BURST))
        begin
            len_sat = BLW'(MAX_BURST);
        end
        else
        begin
            len_sat = BLW'(in_length);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (in_req)
                        REQ_PUT:
                        begin
                            single = 1'b1;
                            if (count_reg >= cap_eff)
                            begin
                                sstat = STAT_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                tail_next  = ring_inc(tail_reg, cap_eff);
                                count_next = count_reg + CW'(1);
                            end
                        end
                        REQ_GET:
                        begin
                            if (count_reg == '0)
                            begin
                                single = 1'b1;
                                sstat  = STAT_EMPTY;
                            end
                            else
                            begin
                                rem_next   = BLW'(1);
                                state_next = ST_READ;
                            end
                        end
                        REQ_PEEK:
                        begin
                            mod_start  = 1'b1;
                            state_next = ST_MOD;
                        end
                        REQ_BURST_RD:
                        begin
                            if (count_reg == '0)
                            begin
                                single = 1'b1;
                                sstat  = STAT_EMPTY;
                            end
                            else if (len_sat == '0)
                            begin
                                single = 1'b1;
                            end
                            else
                            begin
                                if (WW'(len_sat) < WW'(count_reg))
                                begin
                                    rem_next = len_sat;
                                end
                                else
                                begin
                                    rem_next = BLW'(count_reg);
                                end
                                state_next = ST_READ;
                            end
                        end
                        REQ_BW_OPEN:
                        begin
                            single = 1'b1;
                            if (count_reg > cap_eff ||
                                WW'(len_sat) > WW'(cap_eff) - WW'(count_reg))
                            begin
                                bleft_next = '0;
                                sstat      = STAT_FULL;
                            end
                            else
                            begin
                                bleft_next = len_sat;
                            end
                        end
                        REQ_BW_BYTE:
                        begin
                            single = 1'b1;
                            if (bleft_reg == '0)
                            begin
                                sstat = STAT_NO_BURST;
                            end
                            else
                            begin
                                bleft_next = bleft_reg - BLW'(1);
                                if (count_reg >= cap_eff)
                                begin
                                    sstat = STAT_FULL;
                                end
                                else
                                begin
                                    ram_we     = 1'b1;
                                    tail_next  = ring_inc(tail_reg, cap_eff);
                                    count_next = count_reg + CW'(1);
                                end
                            end
                        end
                        default:
                        begin
                            single = 1'b1;
                        end
                    endcase

                    // Single results go straight out or wait in the hold slot.
                    if (single)
                    begin
                        if (slot_free)
                        begin
                            m_valid_next = 1'b1;
                            m_data_next  = '0;
                            m_stat_next  = sstat;
                            m_fill_next  = FILL_W'(count_next);
                            m_last_next  = 1'b1;
                        end
                        else
                        begin
                            pend_stat_next = sstat;
                            state_next     = ST_HOLD;
                        end
                    end
                end
            end
            ST_HOLD:
            begin
                if (slot_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    m_stat_next  = pend_stat_reg;
                    m_fill_next  = FILL_W'(count_reg);
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_MOD:
            begin
                // Peek reads the computed slot without popping.
                if (mod_done)
                begin
                    ram_re       = 1'b1;
                    ram_raddr    = mod_rem;
                    rd_ok_next   = valid_reg[mod_rem];
                    rd_pend_next = 1'b1;
                    rd_last_next = 1'b1;
                    rd_fill_next = count_reg;
                    rem_next     = '0;
                    state_next   = ST_READ;
                end
            end
            ST_READ:
            begin
                // Hand the byte in the RAM output register to the output stage.
                if (rd_pend_reg && slot_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = rd_ok_reg ? ram_rdata : '0;
                    m_stat_next  = STAT_OK;
                    m_fill_next  = FILL_W'(rd_fill_reg);
                    m_last_next  = rd_last_reg;
                end
                // Pop the next byte, or finish once the last one is out.
                if (can_go)
                begin
                    if (rem_reg != '0)
                    begin
                        ram_re       = 1'b1;
                        ram_raddr    = head_reg;
                        rd_ok_next   = valid_reg[head_reg];
                        head_next    = ring_inc(head_reg, cap_eff);
                        count_next   = count_reg - CW'(1);
                        rem_next     = rem_reg - BLW'(1);
                        rd_pend_next = 1'b1;
                        rd_last_next = (rem_reg == BLW'(1));
                        rd_fill_next = count_reg - CW'(1);
                    end
                    else
                    begin
                        rd_pend_next = 1'b0;
                        state_next   = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Capacity write restarts the ring; stored bytes stay.
        if (cfg_wr)
        begin
            cap_next   = pwdata[CAP_W-1:0];
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
            bleft_next = '0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cap_reg     <= CAP_RESET;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            bleft_reg   <= '0;
            rem_reg     <= '0;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cap_reg     <= cap_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            bleft_reg   <= bleft_next;
            rem_reg     <= rem_next;
            rd_pend_reg <= rd_pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Per-slot written marks; an unwritten slot reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ram_we)
        begin
            valid_reg[ram_waddr] <= 1'b1;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        rd_last_reg   <= rd_last_next;
        rd_fill_reg   <= rd_fill_next;
        rd_ok_reg     <= rd_ok_next;
        pend_stat_reg <= pend_stat_next;
        m_data_reg    <= m_data_next;
        m_stat_reg    <= m_stat_next;
        m_fill_reg    <= m_fill_next;
        m_last_reg    <= m_last_next;
    end

    brf_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    brf_mod_unit #(
        .XW (XW),
        .CW (CW),
        .PW (PW)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (mod_dividend),
        .divisor   (cap_eff),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // Ports.
    assign pready        = 1'b1;
    assign prdata        = APB_W'(cap_reg);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {6'b0, m_fill_reg, m_stat_reg, m_data_reg};
    assign m_axis_tlast  = m_last_reg;

endmodule
`default_nettype wire

/* rtl/brf_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// brf_checker
// Port-level checks of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module brf_checker #(
    parameter int DEPTH = brf_pkg::DEPTH_DEF
) (
    input wire                            clk,
    input wire                            rst_n,
    input wire                            m_axis_tvalid,
    input wire                            m_axis_tready,
    input wire [brf_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    input wire                            m_axis_tlast
);
    import brf_pkg::*;

    logic [DATA_W-1:0] r_data;
    logic [STAT_W-1:0] r_stat;
    logic [FILL_W-1:0] r_fill;

    assign r_data = m_axis_tdata[7:0];
    assign r_stat = m_axis_tdata[9:8];
    assign r_fill = m_axis_tdata[17:10];

    // A stalled result keeps its contents.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // Every error status is a lone result with no data.
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && r_stat != STAT_OK |-> m_axis_tlast && r_data == '0)
        else $error("error result not single or carries data");

    // An empty report means nothing is held.
    a_empty_fill: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && r_stat == STAT_EMPTY |-> r_fill == '0)
        else $error("empty status with nonzero fill level");

    // The fill level never passes the storage depth.
    a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> 32'(r_fill) <= 32'(DEPTH))
        else $error("fill level beyond storage depth");

endmodule

bind byte_ring_fifo_with_peek_unit brf_checker #(.DEPTH(DEPTH)) u_brf_checker (.*);
`default_nettype wire
